@@ design/byte_frame_deframer_checksum_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the byte frame deframer
// Clocked on clock, quiet while reset is high.
// ----------------------------------------------------------------------------
`ifndef BYTE_FRAME_DEFRAMER_CHECKSUM_ASSERT_SVH
`define BYTE_FRAME_DEFRAMER_CHECKSUM_ASSERT_SVH

// Same-cycle implication
`define BFD_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("deframer assertion failed");

// Next-cycle implication
`define BFD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("deframer assertion failed");

`endif

@@ design/bfd_pkg.sv @@
// ----------------------------------------------------------------------------
// bfd_pkg
// Types and constants shared by the byte frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package bfd_pkg;

   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned CSR_INDEX_W = 4;

   localparam logic [BYTE_W-1:0] FIRST_MARKER_RESET  = 8'hCA;
   localparam logic [BYTE_W-1:0] SECOND_MARKER_RESET = 8'hAC;
   localparam logic [BYTE_W-1:0] MIN_FRAME_LEN       = 8'd3;

   // Register indexes on the csr channel
   localparam logic [CSR_INDEX_W-1:0] REG_FIRST_MARKER  = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SECOND_MARKER = 4'd1;

   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   typedef struct packed {
      logic     prev_first_marker;
      logic     in_frame;
      byte_type frame_pos;
      byte_type frame_len;
      byte_type running_sum;
      logic     sum_matched;
   } frame_state_type;

   typedef struct packed {
      byte_type byte_out;
      byte_type position;
      logic     byte_valid;
      logic     frame_end;
      logic     checksum_ok;
      logic     length_error;
      logic     resync;
   } frame_result_type;

   localparam frame_state_type FRAME_STATE_RESET = '{
      prev_first_marker: 1'b0,
      in_frame:          1'b0,
      frame_pos:         '0,
      frame_len:         '0,
      running_sum:       '0,
      sum_matched:       1'b0
   };

endpackage

`default_nettype wire

@@ design/bfd_req_if.sv @@
// ----------------------------------------------------------------------------
// bfd_req_if
// Byte input channel of the deframer.
// ----------------------------------------------------------------------------
`default_nettype none

interface bfd_req_if;
   logic                   valid;
   logic                   ready;
   logic [bfd_pkg::BYTE_W-1:0] byte_in;

   modport source (output valid, output byte_in, input ready);
   modport sink   (input valid, input byte_in, output ready);
endinterface

`default_nettype wire

@@ design/bfd_rsp_if.sv @@
// ----------------------------------------------------------------------------
// bfd_rsp_if
// Result channel of the deframer: one result per received byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface bfd_rsp_if;
   logic                   valid;
   logic                   ready;
   logic [bfd_pkg::BYTE_W-1:0] byte_out;
   logic [bfd_pkg::BYTE_W-1:0] position;
   logic                   byte_valid;
   logic                   frame_end;
   logic                   checksum_ok;
   logic                   length_error;
   logic                   resync;

   modport source (output valid, output byte_out, output position, output byte_valid,
                   output frame_end, output checksum_ok, output length_error,
                   output resync, input ready);
   modport sink   (input valid, input byte_out, input position, input byte_valid,
                   input frame_end, input checksum_ok, input length_error,
                   input resync, output ready);
endinterface

`default_nettype wire

@@ design/bfd_csr_if.sv @@
// ----------------------------------------------------------------------------
// bfd_csr_if
// Register write channel of the deframer.
// ----------------------------------------------------------------------------
`default_nettype none

interface bfd_csr_if;
   logic                        valid;
   logic                        ready;
   logic [bfd_pkg::CSR_INDEX_W-1:0] index;
   logic [bfd_pkg::BYTE_W-1:0]      data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ design/bfd_step.sv @@
// ----------------------------------------------------------------------------
// bfd_step
// Framing step for one byte: next framing state and the result item.
// ----------------------------------------------------------------------------
`default_nettype none

module bfd_step (
   input  wire  bfd_pkg::frame_state_type  state,
   input  wire  bfd_pkg::byte_type         first_marker,
   input  wire  bfd_pkg::byte_type         second_marker,
   input  wire  bfd_pkg::byte_type         byte_in,
   output bfd_pkg::frame_state_type        state_next,
   output bfd_pkg::frame_result_type       result
);
   import bfd_pkg::*;

   always_comb begin
      byte_type len_m1;
      byte_type len_m2;
      len_m1     = state.frame_len - 8'd1;
      len_m2     = state.frame_len - 8'd2;
      state_next = state;

      result              = '0;
      result.byte_out     = byte_in;

      if (state.prev_first_marker && (byte_in == second_marker)) begin
         // Header pair: abandon any partial frame, restart at the length byte
         result.resync = 1'b1;
         state_next    = FRAME_STATE_RESET;
         state_next.in_frame = 1'b1;
      end else begin
         state_next.prev_first_marker = (byte_in == first_marker);
         if (state.in_frame) begin
            if (state.frame_pos == '0) begin
               if (byte_in < MIN_FRAME_LEN) begin
                  result.length_error = 1'b1;
                  state_next.in_frame = 1'b0;
               end else begin
                  result.byte_valid      = 1'b1;
                  state_next.frame_len   = byte_in;
                  state_next.running_sum = byte_in;
                  state_next.frame_pos   = 8'd1;
               end
            end else begin
               result.byte_valid = 1'b1;
               result.position   = state.frame_pos;
               if (state.frame_pos < len_m2) begin
                  state_next.running_sum = state.running_sum + byte_in;
               end else if (state.frame_pos == len_m2) begin
                  state_next.sum_matched = (state.running_sum == byte_in);
               end
               if (state.frame_pos == len_m1) begin
                  result.frame_end     = 1'b1;
                  result.checksum_ok   = state.sum_matched;
                  state_next.in_frame  = 1'b0;
                  state_next.frame_pos = '0;
               end else begin
                  state_next.frame_pos = state.frame_pos + 8'd1;
               end
            end
         end
      end
   end

endmodule

`default_nettype wire

@@ design/byte_frame_deframer_checksum.sv @@
// ----------------------------------------------------------------------------
// byte_frame_deframer_checksum
// Hunts for a two-byte header, then passes frame bytes out with their
// position and checks a mod-256 sum against the checksum byte.
// ----------------------------------------------------------------------------
// Takes one byte per clock and gives exactly one result per byte, in the cycle
// after the byte is accepted. The framing state is updated in the same cycle
// the byte is taken, and the result goes into a single output register;
// req ready is high while that register is empty or being drained, so a byte
// can be taken every cycle as long as the result side keeps up. Marker
// registers are written at any time through csr, which never stalls.
`default_nettype none

module byte_frame_deframer_checksum (
   input  wire        clock,
   input  wire        reset,
   bfd_req_if.sink    req_ch,
   bfd_rsp_if.source  rsp_ch,
   bfd_csr_if.sink    csr_ch
);
   import bfd_pkg::*;

   byte_type          first_marker_ff;
   byte_type          second_marker_ff;
   frame_state_type   state_ff;
   frame_state_type   state_in;
   frame_result_type  result_in;
   frame_result_type  rsp_data_ff;
   logic              rsp_valid_ff;
   logic              req_take;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_take     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   bfd_step u_step (
      .state         (state_ff),
      .first_marker  (first_marker_ff),
      .second_marker (second_marker_ff),
      .byte_in       (req_ch.byte_in),
      .state_next    (state_in),
      .result        (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         first_marker_ff  <= FIRST_MARKER_RESET;
         second_marker_ff <= SECOND_MARKER_RESET;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            REG_FIRST_MARKER:  first_marker_ff  <= csr_ch.data;
            REG_SECOND_MARKER: second_marker_ff <= csr_ch.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FRAME_STATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            state_ff <= state_in;
         end
         if (req_take) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload: load on every accepted transaction
   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_data_ff <= result_in;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.byte_out     = rsp_data_ff.byte_out;
   assign rsp_ch.position     = rsp_data_ff.position;
   assign rsp_ch.byte_valid   = rsp_data_ff.byte_valid;
   assign rsp_ch.frame_end    = rsp_data_ff.frame_end;
   assign rsp_ch.checksum_ok  = rsp_data_ff.checksum_ok;
   assign rsp_ch.length_error = rsp_data_ff.length_error;
   assign rsp_ch.resync       = rsp_data_ff.resync;

`include "byte_frame_deframer_checksum_assert.svh"

   `BFD_ASSERT_NEXT(a_take_gives_result, req_take, rsp_valid_ff)
   `BFD_ASSERT_NOW(a_ok_needs_end, rsp_valid_ff && rsp_data_ff.checksum_ok,
      rsp_data_ff.frame_end && rsp_data_ff.byte_valid)
   `BFD_ASSERT_NOW(a_resync_alone, rsp_valid_ff && rsp_data_ff.resync,
      !rsp_data_ff.byte_valid && !rsp_data_ff.length_error && !rsp_data_ff.frame_end)
   `BFD_ASSERT_NOW(a_pos_needs_len, state_ff.frame_pos != '0,
      state_ff.in_frame && (state_ff.frame_len >= MIN_FRAME_LEN))
   `BFD_ASSERT_NEXT(a_resync_restarts, req_take && result_in.resync,
      state_ff.in_frame && (state_ff.frame_pos == '0))

endmodule

`default_nettype wire

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the byte frame deframer against a cycle-free predictor: every byte
// sent in is deframed by the scoreboard, and each result that comes out is
// compared field by field with the oldest expected one. Directed bytes cover
// hunting, header pairs, short lengths, good and bad checksums and markers
// inside a frame; random phases with several marker settings follow.
// ----------------------------------------------------------------------------

module testbench;
   import bfd_pkg::*;

   localparam int unsigned STALL_LIMIT = 500;
   localparam int unsigned PHASES      = 5;
   localparam int unsigned PHASE_BYTES = 215;

   class deframer_scoreboard;
      byte_type         first_marker;
      byte_type         second_marker;
      frame_state_type  st;
      frame_result_type expected_results[$];
      int unsigned      mismatch_count;
      int unsigned      result_count;

      function new();
         first_marker   = FIRST_MARKER_RESET;
         second_marker  = SECOND_MARKER_RESET;
         st             = FRAME_STATE_RESET;
         mismatch_count = 0;
         result_count   = 0;
      endfunction

      function void set_marker(csr_index_type idx, byte_type val);
         case (idx)
            REG_FIRST_MARKER:  first_marker = val;
            REG_SECOND_MARKER: second_marker = val;
            default: ;
         endcase
      endfunction

      function frame_result_type deframe_byte(byte_type b);
         frame_result_type r;
         byte_type         sum_pos;
         byte_type         end_pos;
         r = '0;
         r.byte_out = b;
         sum_pos = st.frame_len - 8'd2;
         end_pos = st.frame_len - 8'd1;
         if (st.prev_first_marker && b == second_marker) begin
            // header pair consumed: restart framing at the length byte
            r.resync    = 1'b1;
            st          = FRAME_STATE_RESET;
            st.in_frame = 1'b1;
         end else begin
            st.prev_first_marker = (b == first_marker);
            if (st.in_frame) begin
               if (st.frame_pos == '0) begin
                  if (b < MIN_FRAME_LEN) begin
                     r.length_error = 1'b1;
                     st.in_frame    = 1'b0;
                  end else begin
                     r.byte_valid   = 1'b1;
                     st.frame_len   = b;
                     st.running_sum = b;
                     st.frame_pos   = 8'd1;
                  end
               end else begin
                  r.byte_valid = 1'b1;
                  r.position   = st.frame_pos;
                  if (st.frame_pos < sum_pos) begin
                     st.running_sum = st.running_sum + b;
                  end else if (st.frame_pos == sum_pos) begin
                     st.sum_matched = (st.running_sum == b);
                  end
                  if (st.frame_pos == end_pos) begin
                     r.frame_end    = 1'b1;
                     r.checksum_ok  = st.sum_matched;
                     st.in_frame    = 1'b0;
                     st.frame_pos   = '0;
                  end else begin
                     st.frame_pos = st.frame_pos + 8'd1;
                  end
               end
            end
         end
         return r;
      endfunction

      function void note_byte(byte_type b);
         expected_results.push_back(deframe_byte(b));
      endfunction

      task report_mismatch(string what);
         mismatch_count++;
         $display("[%0t] deframer result %0d: %s", $realtime, result_count, what);
      endtask

      function string show(frame_result_type r);
         return $sformatf("out=%h pos=%0d valid=%b end=%b ok=%b lerr=%b resync=%b",
                          r.byte_out, r.position, r.byte_valid, r.frame_end,
                          r.checksum_ok, r.length_error, r.resync);
      endfunction

      task check_result(frame_result_type got);
         frame_result_type want;
         string            bad;
         bad = "";
         if (expected_results.size() == 0) begin
            report_mismatch({"unexpected transaction ", show(got)});
         end else begin
            want = expected_results.pop_front();
            if (got.byte_out !== want.byte_out)         bad = {bad, " byte_out"};
            if (got.position !== want.position)         bad = {bad, " position"};
            if (got.byte_valid !== want.byte_valid)     bad = {bad, " byte_valid"};
            if (got.frame_end !== want.frame_end)       bad = {bad, " frame_end"};
            if (got.checksum_ok !== want.checksum_ok)   bad = {bad, " checksum_ok"};
            if (got.length_error !== want.length_error) bad = {bad, " length_error"};
            if (got.resync !== want.resync)             bad = {bad, " resync"};
            if (bad != "")
               report_mismatch({"wrong", bad, ": got ", show(got), " want ", show(want)});
         end
         result_count++;
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;

   bfd_req_if req_ch();
   bfd_rsp_if rsp_ch();
   bfd_csr_if csr_ch();

   byte_frame_deframer_checksum u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   deframer_scoreboard sb = new();

   bit               idle_enable;
   int unsigned      framed_byte_count;
   int unsigned      quiet_cycles = 0;
   frame_result_type seen_result;

   byte_type directed_bytes[$] = {
      8'h00, 8'hFF, 8'hAC,                     // hunting, lone second marker
      8'hCA, 8'hAC, 8'h02,                     // short length
      8'hCA, 8'hAC, 8'h03, 8'h03, 8'h7E,       // shortest frame, good sum
      8'hCA, 8'hAC, 8'h04, 8'h10, 8'h15, 8'hFF,// bad sum
      8'hCA, 8'hAC, 8'h05, 8'h11,              // abandoned by a new header
      8'hCA, 8'hAC, 8'h04, 8'hCA, 8'hCE, 8'h00 // first marker as frame data
   };

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Result side: random stall bursts, each ended by raising ready
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (idle_enable && $urandom_range(0, 5) == 0) begin
            rsp_ch.ready = 1'b0;
            repeat ($urandom_range(1, 8) - 1) @(negedge clock);
            @(negedge clock);
         end
         rsp_ch.ready = 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen_result = '{byte_out:     rsp_ch.byte_out,
                            position:     rsp_ch.position,
                            byte_valid:   rsp_ch.byte_valid,
                            frame_end:    rsp_ch.frame_end,
                            checksum_ok:  rsp_ch.checksum_ok,
                            length_error: rsp_ch.length_error,
                            resync:       rsp_ch.resync};
            sb.check_result(seen_result);
         end
         if (req_ch.valid && req_ch.ready)
            sb.note_byte(req_ch.byte_in);
         if (csr_ch.valid && csr_ch.ready)
            sb.set_marker(csr_ch.index, csr_ch.data);
         if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready) ||
             (csr_ch.valid && csr_ch.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   task automatic send_byte(input byte_type b);
      int unsigned gap;
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 8);
         repeat (gap) begin
            @(negedge clock);
            req_ch.valid   = 1'b0;
            req_ch.byte_in = byte_type'($urandom_range(0, 255));
         end
      end
      @(negedge clock);
      req_ch.valid   = 1'b1;
      req_ch.byte_in = b;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic send_header();
      send_byte(sb.first_marker);
      send_byte(sb.second_marker);
      framed_byte_count += 2;
   endtask

   // Header, then the first keep bytes of a frame of length len
   task automatic send_frame(input int unsigned len, input bit good_sum,
                             input int unsigned keep);
      byte_type frame_q[$];
      byte_type sum;
      byte_type b;
      frame_q.push_back(byte_type'(len));
      sum = byte_type'(len);
      for (int unsigned p = 1; p + 2 < len; p++) begin
         b = byte_type'($urandom_range(0, 255));
         sum = sum + b;
         frame_q.push_back(b);
      end
      frame_q.push_back(good_sum ? sum : sum ^ byte_type'($urandom_range(1, 255)));
      frame_q.push_back(byte_type'($urandom_range(0, 255)));
      send_header();
      for (int unsigned i = 0; i < keep; i++)
         send_byte(frame_q[i]);
      framed_byte_count += keep;
   endtask

   // Drop valid and hold until every expected result has come back
   task automatic wait_for_results();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (sb.expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_marker(input csr_index_type idx, input byte_type val);
      @(negedge clock);
      csr_ch.valid = 1'b1;
      csr_ch.index = idx;
      csr_ch.data  = val;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   task automatic run_traffic(input int unsigned target, input bit allow_idle);
      int unsigned pick;
      int unsigned n;
      int unsigned len;
      while (framed_byte_count < target) begin
         idle_enable = allow_idle && ($urandom_range(0, 9) < 7);
         pick = $urandom_range(0, 99);
         n    = $urandom_range(0, 99);
         if (n < 85)
            len = $urandom_range(3, 12);
         else if (n < 98)
            len = $urandom_range(13, 40);
         else
            len = $urandom_range(41, 255);
         if (pick < 70) begin
            send_frame(len, $urandom_range(0, 4) != 0, len);
         end else if (pick < 80) begin
            // cut short; the next header abandons it
            send_frame(len, 1'b1, $urandom_range(1, len - 1));
         end else if (pick < 88) begin
            send_header();
            send_byte(byte_type'($urandom_range(0, 2)));
            framed_byte_count += 1;
         end else begin
            repeat ($urandom_range(1, 6)) send_byte(byte_type'($urandom_range(0, 255)));
         end
      end
   endtask

   initial begin
      byte_type first_val;
      byte_type second_val;

      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.byte_in = '0;
      csr_ch.valid   = 1'b0;
      csr_ch.index   = REG_FIRST_MARKER;
      csr_ch.data    = '0;
      idle_enable    = 1'b1;
      framed_byte_count = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_bytes[i])
         send_byte(directed_bytes[i]);
      framed_byte_count = directed_bytes.size();
      wait_for_results();

      for (int unsigned ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: begin first_val = 8'h00; second_val = 8'hFF; end
            1: begin first_val = 8'hFF; second_val = 8'h00; end
            2: begin
               // both markers the same value
               first_val  = byte_type'($urandom_range(0, 255));
               second_val = first_val;
            end
            3: begin
               first_val  = byte_type'($urandom_range(0, 255));
               second_val = byte_type'($urandom_range(0, 255));
            end
            default: begin
               first_val  = FIRST_MARKER_RESET;
               second_val = SECOND_MARKER_RESET;
            end
         endcase
         write_marker(REG_FIRST_MARKER, first_val);
         write_marker(REG_SECOND_MARKER, second_val);
         if (ph == 1) begin
            idle_enable = 1'b1;
            send_frame(255, 1'b1, 255);
         end
         run_traffic(directed_bytes.size() + (ph + 1) * PHASE_BYTES, ph != PHASES - 1);
         wait_for_results();
      end

      if (sb.mismatch_count == 0 && sb.expected_results.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

@@ byte_frame_deframer_checksum.f @@
+incdir+design
design/bfd_pkg.sv
design/bfd_req_if.sv
design/bfd_rsp_if.sv
design/bfd_csr_if.sv
design/bfd_step.sv
design/byte_frame_deframer_checksum.sv
test/testbench.sv
